>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the gait oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property, disabled while reset is asserted.
`define SGO_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define SGO_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SGO_ASSERT(name, clk, rst_n, prop, msg)
`define SGO_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> hw/rtl/sgo_pkg.sv
// Types, constants and tables of the servo gait oscillator.
`default_nettype none

package sgo_pkg;

  // Widths
  localparam int TIME_BITS      = 32;
  localparam int SINE_FRAC_BITS = 15;
  localparam int MAG_W          = SINE_FRAC_BITS + 1;
  localparam int NUM_W          = SINE_FRAC_BITS + 10;
  localparam int AMP_W          = 7;
  localparam int ANGLE_W        = 8;
  localparam int PHASE_W        = 10;
  localparam int DEG_W          = 9;
  localparam int IDX_W          = 7;
  localparam int ACT_W          = 2;
  localparam int INTERVAL_W     = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // Table rescale shifts
  localparam int SH_UP = (SINE_FRAC_BITS >= 15) ? SINE_FRAC_BITS - 15 : 0;
  localparam int SH_DN = (SINE_FRAC_BITS < 15) ? 15 - SINE_FRAC_BITS : 1;

  // Degree constants
  localparam logic [DEG_W-1:0]   DEG_90      = 9'd90;
  localparam logic [DEG_W-1:0]   DEG_180     = 9'd180;
  localparam logic [DEG_W-1:0]   DEG_270     = 9'd270;
  localparam logic [DEG_W-1:0]   DEG_360     = 9'd360;
  localparam logic [IDX_W-1:0]   QUARTER_IDX = 7'd90;
  localparam logic signed [PHASE_W-1:0] PHASE_WRAP = -10'sd1;
  localparam logic signed [PHASE_W-1:0] PHASE_LAST = 10'sd359;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;

  // Register reset values
  localparam logic [ANGLE_W-1:0]    CENTRE_RST   = 8'd90;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_LEG_CENTRE   = 3'd0,
    CFG_RIGHT_LEG_CENTRE  = 3'd1,
    CFG_LEFT_FOOT_CENTRE  = 3'd2,
    CFG_RIGHT_FOOT_CENTRE = 3'd3,
    CFG_STEP_INTERVAL     = 3'd4
  } cfg_idx_e;

  // Oscillator state entry
  typedef struct packed {
    logic [TIME_BITS-1:0]      stamp;
    logic signed [PHASE_W-1:0] phase;
  } st_t;

  // Folded angle: quarter-wave index plus sign
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
  } fold_t;

  // Amplitudes per action (forward, backward, turn left, turn right)
  localparam logic signed [AMP_W-1:0] AMP_LL [4] = '{7'sd45, -7'sd45, 7'sd50, 7'sd14};
  localparam logic signed [AMP_W-1:0] AMP_RL [4] = '{7'sd45, -7'sd45, 7'sd14, 7'sd50};
  localparam logic signed [AMP_W-1:0] AMP_LF [4] = '{7'sd25, 7'sd25, 7'sd14, 7'sd14};
  localparam logic signed [AMP_W-1:0] AMP_RF [4] = '{7'sd25, 7'sd25, 7'sd30, 7'sd30};

  // Quarter-wave sine in Q1.15
  localparam logic [15:0] SINE_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // Sine magnitude at SINE_FRAC_BITS fraction bits
  function automatic logic [MAG_W-1:0] sine_mag(logic [IDX_W-1:0] idx);
    logic [15:0] raw;
    logic [47:0] wide;
    raw = (idx <= QUARTER_IDX) ? SINE_Q15[idx] : SINE_Q15[QUARTER_IDX];
    if (SINE_FRAC_BITS >= 15) begin
      wide = {32'd0, raw} << SH_UP;
    end else begin
      wide = (({32'd0, raw} >> (SH_DN - 1)) + 48'd1) >> 1;
    end
    return wide[MAG_W-1:0];
  endfunction

  // Fold a whole degree 0..359 onto the quarter wave
  function automatic fold_t fold_deg(logic [DEG_W-1:0] d);
    fold_t f;
    if (d <= DEG_90) begin
      f.idx = IDX_W'(d);
      f.neg = 1'b0;
    end else if (d <= DEG_180) begin
      f.idx = IDX_W'(DEG_180 - d);
      f.neg = 1'b0;
    end else if (d <= DEG_270) begin
      f.idx = IDX_W'(d - DEG_180);
      f.neg = 1'b1;
    end else begin
      f.idx = IDX_W'(DEG_360 - d);
      f.neg = 1'b1;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sgo_if.sv
// Input and output channel interfaces of the servo gait oscillator.
`default_nettype none

interface sgo_in_if;
  logic                           valid;
  logic                           ready;
  logic [sgo_pkg::TIME_BITS-1:0]  now_ms;
  logic [sgo_pkg::ACT_W-1:0]      action;

  modport source (output valid, now_ms, action, input ready);
  modport sink   (input valid, now_ms, action, output ready);
endinterface

interface sgo_out_if;
  logic                          valid;
  logic                          ready;
  logic [sgo_pkg::ANGLE_W-1:0]   left_leg_angle;
  logic [sgo_pkg::ANGLE_W-1:0]   right_leg_angle;
  logic [sgo_pkg::ANGLE_W-1:0]   left_foot_angle;
  logic [sgo_pkg::ANGLE_W-1:0]   right_foot_angle;

  modport source (output valid, left_leg_angle, right_leg_angle, left_foot_angle,
                  right_foot_angle, input ready);
  modport sink   (input valid, left_leg_angle, right_leg_angle, left_foot_angle,
                  right_foot_angle, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/servo_gait_oscillator.sv
// Servo gait oscillator: top level with state memory and four-stage pipeline.
//
// Usage: each input beat on in_i carries a millisecond timestamp and a gait
// action. When the unsigned time since the last recorded update is at least
// step_interval_ms, the block records the timestamp, advances the phase by one
// degree and sends one output beat on out_o with four servo angles; otherwise
// the input beat is consumed and nothing comes out.
// Configuration: write cfg_wdata_i to register cfg_idx_i with cfg_we_i high,
// only while the block is idle. Index 0..3 are the leg and foot centres,
// index 4 the step interval; other indexes are ignored.
// An accepted input beat passes through the state update, the quarter-wave
// lookup, the angle arithmetic and the output register, in that order.
// Throughput: one input beat per cycle while no stall backs up the stages.
// The phase and timestamp live in a one-entry memory read every cycle; a
// bypass register forwards a write-back to an item in the next cycle.
// Reset: registers return to their default values, the state reads as zero
// time and zero phase, and the pipeline empties; no clearing pass is needed.
// Stall: when out_o.ready is low the output register holds its beat and the
// stages behind it fill; in_i.ready drops once the first stage cannot drain.
`default_nettype none
`include "assert_macros.svh"

module servo_gait_oscillator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sgo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sgo_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  sgo_in_if.sink                                 in_i,
  sgo_out_if.source                              out_o
);

  // Configuration registers
  logic [sgo_pkg::ANGLE_W-1:0]    ll_centre_q, rl_centre_q, lf_centre_q, rf_centre_q;
  logic [sgo_pkg::INTERVAL_W-1:0] interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ll_centre_q <= sgo_pkg::CENTRE_RST;
      rl_centre_q <= sgo_pkg::CENTRE_RST;
      lf_centre_q <= sgo_pkg::CENTRE_RST;
      rf_centre_q <= sgo_pkg::CENTRE_RST;
      interval_q  <= sgo_pkg::INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (sgo_pkg::cfg_idx_e'(cfg_idx_i))
        sgo_pkg::CFG_LEFT_LEG_CENTRE:   ll_centre_q <= cfg_wdata_i[sgo_pkg::ANGLE_W-1:0];
        sgo_pkg::CFG_RIGHT_LEG_CENTRE:  rl_centre_q <= cfg_wdata_i[sgo_pkg::ANGLE_W-1:0];
        sgo_pkg::CFG_LEFT_FOOT_CENTRE:  lf_centre_q <= cfg_wdata_i[sgo_pkg::ANGLE_W-1:0];
        sgo_pkg::CFG_RIGHT_FOOT_CENTRE: rf_centre_q <= cfg_wdata_i[sgo_pkg::ANGLE_W-1:0];
        sgo_pkg::CFG_STEP_INTERVAL:     interval_q  <= cfg_wdata_i[sgo_pkg::INTERVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline handshake
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_v_d, s2_v_d, s3_v_d, out_v_d;
  logic out_free, s3_free, s2_free;
  logic fire, s1_go, s1_fwd, in_acc;

  assign out_free = !out_v_q || out_o.ready;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_go    = s1_v_q && (!fire || s2_free);
  assign s1_fwd   = s1_v_q && fire && s2_free;
  assign in_i.ready = !s1_v_q || s1_go;
  assign in_acc   = in_i.valid && in_i.ready;

  always_comb begin
    s1_v_d  = in_i.ready ? in_i.valid : s1_v_q;
    s2_v_d  = s2_free ? s1_fwd : s2_v_q;
    s3_v_d  = s3_free ? s2_v_q : s3_v_q;
    out_v_d = out_free ? s3_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      s3_v_q  <= s3_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Stage 1 payload
  logic [sgo_pkg::TIME_BITS-1:0] s1_now_q;
  logic [sgo_pkg::ACT_W-1:0]     s1_act_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_now_q <= in_i.now_ms;
      s1_act_q <= in_i.action;
    end
  end

  // State memory: one entry, synchronous read, bypass on write-back
  sgo_pkg::st_t st_mem [1];
  sgo_pkg::st_t rd_q, byp_q, cur_st, st_wdata;
  logic         mem_v_q, rd_v_q, byp_v_q, st_we;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[0] <= st_wdata;
    end
    rd_q <= st_mem[0];
    if (st_we) begin
      byp_q <= st_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_v_q <= 1'b0;
      rd_v_q  <= 1'b0;
      byp_v_q <= 1'b0;
    end else begin
      if (st_we) begin
        mem_v_q <= 1'b1;
      end
      rd_v_q  <= mem_v_q;
      byp_v_q <= st_we;
    end
  end

  // Pick forwarded, stored or reset state
  always_comb begin
    if (byp_v_q) begin
      cur_st = byp_q;
    end else if (rd_v_q) begin
      cur_st = rd_q;
    end else begin
      cur_st = '0;
    end
  end

  // Interval check and phase advance
  logic [sgo_pkg::TIME_BITS-1:0]     elapsed;
  logic signed [sgo_pkg::PHASE_W-1:0] p_full;
  logic [sgo_pkg::DEG_W-1:0]         p_deg, sin_deg, cos_deg;
  logic [sgo_pkg::DEG_W:0]           q_deg;

  assign elapsed = s1_now_q - cur_st.stamp;
  assign fire    = elapsed >= sgo_pkg::TIME_BITS'(interval_q);
  assign p_full  = cur_st.phase + sgo_pkg::PHASE_W'(1);
  assign p_deg   = p_full[sgo_pkg::DEG_W-1:0];
  assign sin_deg = (p_deg == sgo_pkg::DEG_360) ? '0 : p_deg;
  assign q_deg   = {1'b0, p_deg} + {1'b0, sgo_pkg::DEG_90};
  assign cos_deg = (q_deg >= {1'b0, sgo_pkg::DEG_360})
                 ? sgo_pkg::DEG_W'(q_deg - {1'b0, sgo_pkg::DEG_360})
                 : sgo_pkg::DEG_W'(q_deg);

  assign st_we          = s1_fwd;
  assign st_wdata.stamp = s1_now_q;
  assign st_wdata.phase = (p_deg == sgo_pkg::DEG_360) ? sgo_pkg::PHASE_WRAP
                                                      : $signed({1'b0, p_deg});

  // Stage 2: folded indices
  sgo_pkg::fold_t            s2_sin_q, s2_cos_q;
  logic [sgo_pkg::ACT_W-1:0] s2_act_q;

  always_ff @(posedge clk_i) begin
    if (s1_fwd) begin
      s2_sin_q <= sgo_pkg::fold_deg(sin_deg);
      s2_cos_q <= sgo_pkg::fold_deg(cos_deg);
      s2_act_q <= s1_act_q;
    end
  end

  // Stage 3: quarter-wave lookup
  logic [sgo_pkg::MAG_W-1:0] s3_sin_mag_q, s3_cos_mag_q;
  logic                      s3_sin_neg_q, s3_cos_neg_q;
  logic [sgo_pkg::ACT_W-1:0] s3_act_q;

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_v_q) begin
      s3_sin_mag_q <= sgo_pkg::sine_mag(s2_sin_q.idx);
      s3_cos_mag_q <= sgo_pkg::sine_mag(s2_cos_q.idx);
      s3_sin_neg_q <= s2_sin_q.neg;
      s3_cos_neg_q <= s2_cos_q.neg;
      s3_act_q     <= s2_act_q;
    end
  end

  // Angle arithmetic
  logic [sgo_pkg::ANGLE_W-1:0] ll_ang, rl_ang, lf_ang, rf_ang;

  sgo_angle u_left_leg (
    .centre_i (ll_centre_q),
    .amp_i    (sgo_pkg::AMP_LL[s3_act_q]),
    .mag_i    (s3_cos_mag_q),
    .neg_i    (s3_cos_neg_q),
    .angle_o  (ll_ang)
  );

  sgo_angle u_right_leg (
    .centre_i (rl_centre_q),
    .amp_i    (sgo_pkg::AMP_RL[s3_act_q]),
    .mag_i    (s3_cos_mag_q),
    .neg_i    (s3_cos_neg_q),
    .angle_o  (rl_ang)
  );

  sgo_angle u_left_foot (
    .centre_i (lf_centre_q),
    .amp_i    (sgo_pkg::AMP_LF[s3_act_q]),
    .mag_i    (s3_sin_mag_q),
    .neg_i    (s3_sin_neg_q),
    .angle_o  (lf_ang)
  );

  sgo_angle u_right_foot (
    .centre_i (rf_centre_q),
    .amp_i    (sgo_pkg::AMP_RF[s3_act_q]),
    .mag_i    (s3_sin_mag_q),
    .neg_i    (s3_sin_neg_q),
    .angle_o  (rf_ang)
  );

  // Output register: hold while stalled
  logic [sgo_pkg::ANGLE_W-1:0] out_ll_q, out_rl_q, out_lf_q, out_rf_q;

  always_ff @(posedge clk_i) begin
    if (out_free && s3_v_q) begin
      out_ll_q <= ll_ang;
      out_rl_q <= rl_ang;
      out_lf_q <= lf_ang;
      out_rf_q <= rf_ang;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.left_leg_angle   = out_ll_q;
  assign out_o.right_leg_angle  = out_rl_q;
  assign out_o.left_foot_angle  = out_lf_q;
  assign out_o.right_foot_angle = out_rf_q;

  // Checks
  `SGO_ASSERT(a_state_fwd, clk_i, rst_ni, st_we |=> (cur_st == $past(st_wdata)),
              "state bypass lost a write-back")
  `SGO_ASSERT(a_phase_range, clk_i, rst_ni,
              s1_v_q |-> ((cur_st.phase >= sgo_pkg::PHASE_WRAP) &&
                          (cur_st.phase <= sgo_pkg::PHASE_LAST)),
              "stored phase out of range")
  `SGO_ASSERT(a_fold_range, clk_i, rst_ni,
              s2_v_q |-> ((s2_sin_q.idx <= sgo_pkg::QUARTER_IDX) &&
                          (s2_cos_q.idx <= sgo_pkg::QUARTER_IDX)),
              "folded index beyond quarter wave")
  `SGO_ASSERT(a_angle_range, clk_i, rst_ni,
              out_v_q |-> ((out_ll_q <= sgo_pkg::ANGLE_MAX) && (out_rl_q <= sgo_pkg::ANGLE_MAX) &&
                           (out_lf_q <= sgo_pkg::ANGLE_MAX) && (out_rf_q <= sgo_pkg::ANGLE_MAX)),
              "servo angle above limit")

endmodule

`default_nettype wire

>>> hw/rtl/sgo_angle.sv
// One servo angle: centre plus amplitude times signed sine, truncated and saturated.
`default_nettype none

module sgo_angle (
  input  wire logic [sgo_pkg::ANGLE_W-1:0]        centre_i,
  input  wire logic signed [sgo_pkg::AMP_W-1:0]   amp_i,
  input  wire logic [sgo_pkg::MAG_W-1:0]          mag_i,
  input  wire logic                               neg_i,
  output logic      [sgo_pkg::ANGLE_W-1:0]        angle_o
);

  localparam int F      = sgo_pkg::SINE_FRAC_BITS;
  localparam int NW     = sgo_pkg::NUM_W;
  localparam int PROD_W = sgo_pkg::AMP_W + sgo_pkg::MAG_W + 1;
  localparam int WHOLE_W = NW - F;

  logic signed [sgo_pkg::MAG_W:0] sine_s;
  logic signed [PROD_W-1:0]       prod;
  logic signed [NW-1:0]           centre_s;
  logic signed [NW-1:0]           num;
  logic        [WHOLE_W-1:0]      whole;

  // Apply the quadrant sign
  assign sine_s = neg_i ? -$signed({1'b0, mag_i}) : $signed({1'b0, mag_i});

  // Scale and offset by the centre
  assign prod     = PROD_W'(amp_i) * PROD_W'(sine_s);
  assign centre_s = $signed({{(NW - sgo_pkg::ANGLE_W - F){1'b0}}, centre_i, {F{1'b0}}});
  assign num      = centre_s + NW'(prod);
  assign whole    = num[NW-1:F];

  // Clamp to the servo range
  always_comb begin
    if (num[NW-1]) begin
      angle_o = '0;
    end else if (whole > WHOLE_W'(sgo_pkg::ANGLE_MAX)) begin
      angle_o = sgo_pkg::ANGLE_MAX;
    end else begin
      angle_o = whole[sgo_pkg::ANGLE_W-1:0];
    end
  end

endmodule

`default_nettype wire
